// ===== rtl/core/ttcw_pkg.sv =====
// Shared widths and register indexes of the texture coordinate wrap unit.
`default_nettype none

package ttcw_pkg;

  // Fraction bits of every fixed point value (one = 1 << FRAC_BITS)
  localparam int FRAC_BITS  = 16;

  // Fixed field widths
  localparam int POS_W      = 20;
  localparam int CTR_W      = 19;
  localparam int INV_W      = 23;
  localparam int PH_W       = 17;
  localparam int TEX_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_INV_TILE_X = 3'd2,
    REG_INV_TILE_Y = 3'd3,
    REG_PHASE      = 3'd4,
    REG_MIRROR     = 3'd5,
    REG_CLAMP      = 3'd6,
    REG_PHASE_HORZ = 3'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/tiled_texture_coordinate_wrap_unit.sv =====
// Texture coordinate generator: tile scaling, clamp, row offset, repeat and mirror.
`default_nettype none

// Maps one output pixel position (in_pos_x, in_pos_y, signed Q3.FRAC_BITS) to a
// source texture coordinate (out_tex_u, out_tex_v, 0 to 1.0 inclusive). Each axis
// is centered on the tile grid center, scaled by the reciprocal tile size, rounded
// to nearest (ties up) and offset by one half, so the central tile spans [0,1).
// Clamp mode saturates both axes to [0,1]; otherwise the odd tile rows (or columns)
// are shifted by the phase, the coordinate wraps to its fraction, and mirror mode
// reflects that fraction in odd tiles. The datapath is a five stage pipeline:
// subtract, multiply (21 x 24 bit), round, clamp/phase, wrap/mirror. The output is
// registered, and the unit takes one beat per cycle while in_stall is low. Each
// stage advances whenever the stage after it is empty or moving, so bubbles are
// squeezed out and in_stall rises only when every stage holds a beat
// and the output is stalled. Configuration is read live by the pipeline; write it
// only while no beat is in flight. Indexes 0..7 cover all registers.
module tiled_texture_coordinate_wrap_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // input channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [ttcw_pkg::POS_W-1:0]      in_pos_x,
  input  wire logic signed [ttcw_pkg::POS_W-1:0]      in_pos_y,
  // result channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic             [ttcw_pkg::TEX_W-1:0]      out_tex_u,
  output logic             [ttcw_pkg::TEX_W-1:0]      out_tex_v,
  // configuration port
  input  wire logic                                   cfg_we,
  input  wire logic        [ttcw_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic        [ttcw_pkg::CFG_DATA_W-1:0] cfg_data
);

  import ttcw_pkg::*;

  // Datapath widths follow from the field widths and FRAC_BITS.
  localparam int DIFF_W = POS_W + 1;              // pos - center
  localparam int PROD_W = DIFF_W + INV_W + 1;     // signed product
  localparam int Q_W    = PROD_W + 4;             // room for rounding constant
  localparam int F_W    = FRAC_BITS + 1;          // fraction plus tile parity bit

  localparam logic signed [Q_W-1:0] HALF_Q = Q_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [Q_W-1:0] ONE_Q  = Q_W'(1) << FRAC_BITS;
  // Round to nearest, then add one half: fold both into one constant ahead of the shift.
  localparam logic signed [Q_W-1:0] RND_Q  = HALF_Q + (HALF_Q << FRAC_BITS);
  localparam logic [F_W-1:0]        ONE_F  = F_W'(1) << FRAC_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [CTR_W-1:0] center_x_r, center_y_r;
  logic        [INV_W-1:0] inv_x_r, inv_y_r;
  logic        [PH_W-1:0]  phase_r;
  logic                    mirror_r, clamp_r, phase_horz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= CTR_W'(1) << (FRAC_BITS - 1);
      center_y_r   <= CTR_W'(1) << (FRAC_BITS - 1);
      inv_x_r      <= INV_W'(1) << FRAC_BITS;
      inv_y_r      <= INV_W'(1) << FRAC_BITS;
      phase_r      <= '0;
      mirror_r     <= 1'b0;
      clamp_r      <= 1'b0;
      phase_horz_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_CENTER_X:   center_x_r   <= cfg_data[CTR_W-1:0];
        REG_CENTER_Y:   center_y_r   <= cfg_data[CTR_W-1:0];
        REG_INV_TILE_X: inv_x_r      <= cfg_data[INV_W-1:0];
        REG_INV_TILE_Y: inv_y_r      <= cfg_data[INV_W-1:0];
        REG_PHASE:      phase_r      <= cfg_data[PH_W-1:0];
        REG_MIRROR:     mirror_r     <= cfg_data[0];
        REG_CLAMP:      clamp_r      <= cfg_data[0];
        REG_PHASE_HORZ: phase_horz_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its successor loads.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5      = !v5_r || !out_stall;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: center the position on the grid center.
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt, dx_r, dy_r;

  assign dx_nxt = DIFF_W'(in_pos_x) - DIFF_W'(center_x_r);
  assign dy_nxt = DIFF_W'(in_pos_y) - DIFF_W'(center_y_r);

  // Stage 2: scale by the reciprocal tile size (reciprocal is unsigned).
  logic signed [PROD_W-1:0] px_nxt, py_nxt, px_r, py_r;

  assign px_nxt = PROD_W'(dx_r) * PROD_W'($signed({1'b0, inv_x_r}));
  assign py_nxt = PROD_W'(dy_r) * PROD_W'($signed({1'b0, inv_y_r}));

  // Stage 3: round to nearest, drop the fraction of the product, add one half.
  logic signed [Q_W-1:0] sx_sum, sy_sum;
  logic signed [Q_W-1:0] qx_nxt, qy_nxt, qx_r, qy_r;

  assign sx_sum = Q_W'(px_r) + RND_Q;
  assign sy_sum = Q_W'(py_r) + RND_Q;
  assign qx_nxt = sx_sum >>> FRAC_BITS;
  assign qy_nxt = sy_sum >>> FRAC_BITS;

  // Stage 4: clamp, or apply the alternate row/column offset. Only the fraction and
  // the tile parity bit matter from here on, so the offset is done modulo two tiles.
  logic [F_W-1:0] phase_f;
  logic [F_W-1:0] cx, cy, ox, oy;
  logic [F_W-1:0] ux_nxt, uy_nxt, ux_r, uy_r;

  assign phase_f = F_W'(phase_r);

  always_comb begin
    // clamp each axis to [0, one]
    if (qx_r[Q_W-1])       cx = '0;
    else if (qx_r > ONE_Q) cx = ONE_F;
    else                   cx = qx_r[F_W-1:0];
    if (qy_r[Q_W-1])       cy = '0;
    else if (qy_r > ONE_Q) cy = ONE_F;
    else                   cy = qy_r[F_W-1:0];

    // shift one axis by the parity of the other axis's tile
    ox = qx_r[F_W-1:0];
    oy = qy_r[F_W-1:0];
    if (phase_horz_r) begin
      if (qy_r[FRAC_BITS]) ox = qx_r[F_W-1:0] - phase_f;
    end else begin
      if (qx_r[FRAC_BITS]) oy = qy_r[F_W-1:0] - phase_f;
    end

    ux_nxt = clamp_r ? cx : ox;
    uy_nxt = clamp_r ? cy : oy;
  end

  // Stage 5: wrap to the fraction, reflect in odd tiles when mirroring.
  logic [F_W-1:0] tu_nxt, tv_nxt, tu_r, tv_r;

  always_comb begin
    if (clamp_r) begin
      tu_nxt = ux_r;
      tv_nxt = uy_r;
    end else begin
      tu_nxt = {1'b0, ux_r[FRAC_BITS-1:0]};
      tv_nxt = {1'b0, uy_r[FRAC_BITS-1:0]};
      if (mirror_r && ux_r[FRAC_BITS]) tu_nxt = ONE_F - {1'b0, ux_r[FRAC_BITS-1:0]};
      if (mirror_r && uy_r[FRAC_BITS]) tv_nxt = ONE_F - {1'b0, uy_r[FRAC_BITS-1:0]};
    end
  end

  // Payload registers: load with the stage enable, no reset needed.
  always_ff @(posedge clk) begin
    if (en1) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (en2) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
    if (en3) begin
      qx_r <= qx_nxt;
      qy_r <= qy_nxt;
    end
    if (en4) begin
      ux_r <= ux_nxt;
      uy_r <= uy_nxt;
    end
    if (en5) begin
      tu_r <= tu_nxt;
      tv_r <= tv_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_tex_u = TEX_W'(tu_r);
  assign out_tex_v = TEX_W'(tv_r);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input is held off only when every stage is full and the output is stalled.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && v5_r && out_stall))
    else $error("input stalled with a free pipeline stage");

  // An accepted beat lands in the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted beat lost at stage one");

  // A result never exceeds one.
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (tu_r <= ONE_F) && (tv_r <= ONE_F))
    else $error("texture coordinate above one");

  // Plain repeat mode yields a fraction strictly below one.
  a_repeat_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !clamp_r && !mirror_r) |-> (!tu_r[FRAC_BITS] && !tv_r[FRAC_BITS]))
    else $error("repeat mode coordinate reached one");

  // A stalled result is not disturbed by the stages behind it.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && out_stall) |=> (v5_r && $stable(tu_r) && $stable(tv_r)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the tiled texture coordinate wrap unit.
`timescale 1ns / 1ps

module tb;
  import ttcw_pkg::*;

  localparam int     FRAC     = FRAC_BITS;
  localparam longint ONE      = longint'(1) << FRAC;
  localparam longint HALF     = longint'(1) << (FRAC - 1);
  localparam int     LATENCY  = 5;     // input beat to output register
  localparam int     N_RANDOM = 1950;  // at least this many random pixel beats over all idle mixes
  localparam int     N_CHUNKS = 8;     // register settings per idle mix

  // One full register set, kept as the predictor's view of the unit.
  typedef struct {
    logic signed [CTR_W-1:0] ctr_x;
    logic signed [CTR_W-1:0] ctr_y;
    logic        [INV_W-1:0] inv_x;
    logic        [INV_W-1:0] inv_y;
    logic        [PH_W-1:0]  phase;
    logic                    mirror;
    logic                    clamp;
    logic                    horiz;
  } settings_t;

  typedef struct packed {
    logic [TEX_W-1:0] u;
    logic [TEX_W-1:0] v;
  } texel_t;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic signed [POS_W-1:0]    in_pos_x  = '0;
  logic signed [POS_W-1:0]    in_pos_y  = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic        [TEX_W-1:0]    out_tex_u;
  logic        [TEX_W-1:0]    out_tex_v;
  logic                       cfg_we    = 1'b0;
  logic        [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic        [CFG_DATA_W-1:0] cfg_data = '0;

  settings_t live;               // registers as the unit holds them now
  texel_t    pending_texels[$];  // predicted coordinates, oldest first
  texel_t    want_texel;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_settings = 0;
  int        n_errors = 0;

  tiled_texture_coordinate_wrap_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_tex_u (out_tex_u),
    .out_tex_v (out_tex_v),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Coordinate predictor
  // ---------------------------------------------------------------------------

  // Center, scale by the reciprocal tile size, round to nearest with ties
  // toward plus infinity, then shift by one half so the central tile is [0,1).
  // The arithmetic shift on a signed longint is a floor, as the rounding needs.
  function automatic longint tile_coord(logic signed [POS_W-1:0] pos,
                                        logic signed [CTR_W-1:0] ctr,
                                        logic [INV_W-1:0] inv);
    longint prod;
    prod = (longint'(pos) - longint'(ctr)) * longint'(inv);
    return ((prod + HALF) >>> FRAC) + HALF;
  endfunction

  function automatic logic [TEX_W-1:0] clamped(longint q);
    if (q < 0) return '0;
    if (q > ONE) return TEX_W'(ONE);
    return TEX_W'(q);
  endfunction

  // Keep the fraction; bit FRAC of the two's complement value is the parity
  // of floor(q / one), so negative tiles alternate too. A zero fraction in an
  // odd tile mirrors to a full one.
  function automatic logic [TEX_W-1:0] wrapped(longint q, logic mirror);
    longint f;
    f = q & (ONE - 1);
    if (mirror && q[FRAC]) f = ONE - f;
    return TEX_W'(f);
  endfunction

  function automatic texel_t texel_for(settings_t s, logic signed [POS_W-1:0] px,
                                       logic signed [POS_W-1:0] py);
    longint qx;
    longint qy;
    texel_t t;
    qx = tile_coord(px, s.ctr_x, s.inv_x);
    qy = tile_coord(py, s.ctr_y, s.inv_y);
    if (s.clamp) begin
      // phase and mirror play no part in clamp mode
      t.u = clamped(qx);
      t.v = clamped(qy);
    end else begin
      // shift one axis by the parity of the other, before either wraps
      if (s.horiz) begin
        if (qy[FRAC]) qx -= longint'(s.phase);
      end else if (qx[FRAC]) begin
        qy -= longint'(s.phase);
      end
      t.u = wrapped(qx, s.mirror);
      t.v = wrapped(qy, s.mirror);
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Drive one pixel beat. Idle cycles come first, so valid is only ever
  // lowered in a step where it is not raised again; once raised it holds,
  // with its payload, until the beat is taken.
  task automatic send_pos(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge: predict with the registers in force now
    pending_texels = {pending_texels, texel_for(live, px, py)};
    n_sent++;
  endtask

  // Drop valid, wait for every predicted beat, then let the pipe run dry.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Write enable stays high across a burst; apply_settings lowers it once.
  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= d;
    @(posedge clk);
  endtask

  // Write all eight registers while the unit is idle.
  task automatic apply_settings(settings_t s);
    write_reg(REG_CENTER_X,   CFG_DATA_W'(unsigned'(s.ctr_x)));
    write_reg(REG_CENTER_Y,   CFG_DATA_W'(unsigned'(s.ctr_y)));
    write_reg(REG_INV_TILE_X, CFG_DATA_W'(s.inv_x));
    write_reg(REG_INV_TILE_Y, CFG_DATA_W'(s.inv_y));
    write_reg(REG_PHASE,      CFG_DATA_W'(s.phase));
    write_reg(REG_MIRROR,     CFG_DATA_W'(s.mirror));
    write_reg(REG_CLAMP,      CFG_DATA_W'(s.clamp));
    write_reg(REG_PHASE_HORZ, CFG_DATA_W'(s.horiz));
    cfg_we <= 1'b0;
    live = s;
    n_settings++;
  endtask

  function automatic settings_t reset_settings();
    settings_t s;
    s.ctr_x  = CTR_W'(32768);
    s.ctr_y  = CTR_W'(32768);
    s.inv_x  = INV_W'(65536);
    s.inv_y  = INV_W'(65536);
    s.phase  = '0;
    s.mirror = 1'b0;
    s.clamp  = 1'b0;
    s.horiz  = 1'b0;
    return s;
  endfunction

  function automatic logic signed [CTR_W-1:0] pick_center();
    case ($urandom_range(0, 5))
      0:       return CTR_W'(-65536);
      1:       return CTR_W'(131072);
      2, 3:    return CTR_W'($urandom_range(0, 196608) - 65536);
      4:       return CTR_W'(32768 + $urandom_range(0, 8192) - 4096);
      default: return CTR_W'($urandom);  // any bit pattern of the register
    endcase
  endfunction

  function automatic logic [INV_W-1:0] pick_recip();
    case ($urandom_range(0, 7))
      0:       return INV_W'(21845);
      1:       return INV_W'(6553600);
      2:       return '0;                           // degenerate tile size
      3, 4, 5: return INV_W'($urandom_range(21845, 262144));
      6:       return INV_W'($urandom_range(21845, 6553600));
      default: return INV_W'($urandom);
    endcase
  endfunction

  // Chunk 0 takes every low extreme, chunk 1 every high one but clamp, the rest mix.
  function automatic settings_t pick_settings(int chunk);
    settings_t s;
    if (chunk == 0) begin
      s.ctr_x = CTR_W'(-65536);  s.ctr_y = CTR_W'(-65536);
      s.inv_x = INV_W'(21845);   s.inv_y = INV_W'(21845);
      s.phase = '0;
      s.mirror = 1'b0; s.clamp = 1'b0; s.horiz = 1'b0;
    end else if (chunk == 1) begin
      s.ctr_x = CTR_W'(131072);  s.ctr_y = CTR_W'(131072);
      s.inv_x = INV_W'(6553600); s.inv_y = INV_W'(6553600);
      s.phase = PH_W'(131071);
      s.mirror = 1'b1; s.clamp = 1'b0; s.horiz = 1'b1;
    end else begin
      s.ctr_x = pick_center();
      s.ctr_y = pick_center();
      s.inv_x = pick_recip();
      s.inv_y = pick_recip();
      case ($urandom_range(0, 4))
        0:       s.phase = '0;
        1:       s.phase = PH_W'(131071);
        2:       s.phase = PH_W'(65536);
        default: s.phase = PH_W'($urandom);
      endcase
      s.mirror = 1'($urandom_range(0, 1));
      s.clamp  = ($urandom_range(0, 3) == 0);
      s.horiz  = 1'($urandom_range(0, 1));
    end
    return s;
  endfunction

  // Half are positions within a few tiles of the center, a quarter within two of
  // half-tile steps, the rest anywhere in the field.
  function automatic logic signed [POS_W-1:0] pick_pos(logic signed [CTR_W-1:0] ctr);
    case ($urandom_range(0, 3))
      0: return POS_W'($urandom);
      1: return POS_W'(int'(ctr) + $urandom_range(0, 262144) - 131072);
      2: return POS_W'(($urandom_range(0, 31) - 16) * 32768 + $urandom_range(0, 4) - 2);
      default: return POS_W'(int'(ctr) + $urandom_range(0, 16383) - 8192);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers straight out of reset, field extremes.
  task automatic test_reset_values();
    live = reset_settings();
    send_pos(0, 0);
    send_pos(-524288, -524288);
    send_pos(524287, 524287);
    send_pos(-524288, 524287);
    send_pos(32768, -1);
    quiesce();
  endtask

  // Clamp saturates both sides; phase and mirror set but ignored.
  task automatic test_clamp();
    settings_t s;
    s = reset_settings();
    s.clamp  = 1'b1;
    s.mirror = 1'b1;
    s.phase  = PH_W'(65536);
    apply_settings(s);
    send_pos(-70000, 200000);
    send_pos(65536, 0);
    send_pos(32768, 65535);
    send_pos(524287, -524288);
    quiesce();
  endtask

  // Tile edges under mirror: a zero fraction in an odd tile reads back as one,
  // negative tiles alternate.
  task automatic test_mirror_edges();
    settings_t s;
    s = reset_settings();
    s.mirror = 1'b1;
    apply_settings(s);
    send_pos(65536, -65536);
    send_pos(131072, -131072);
    send_pos(0, 65535);
    send_pos(196608, -1);
    quiesce();
  endtask

  // Odd columns shift y, then odd rows shift x with the largest phase.
  task automatic test_phase_offset();
    settings_t s;
    s = reset_settings();
    s.phase = PH_W'(32768);
    apply_settings(s);
    send_pos(65536 + 100, 20000);
    send_pos(100, 20000);
    quiesce();
    s.phase = PH_W'(131071);
    s.horiz = 1'b1;
    apply_settings(s);
    send_pos(20000, 65536 + 5);
    send_pos(20000, 5);
    quiesce();
  endtask

  // A zero reciprocal pins every position to mid-tile.
  task automatic test_zero_recip();
    settings_t s;
    s = reset_settings();
    s.inv_x  = '0;
    s.inv_y  = '0;
    s.mirror = 1'b1;
    apply_settings(s);
    send_pos(524287, -524288);
    send_pos(0, 0);
    quiesce();
  endtask

  // Products that land exactly halfway round toward plus infinity.
  task automatic test_rounding_ties();
    settings_t s;
    s = reset_settings();
    s.ctr_x = '0;
    s.ctr_y = '0;
    s.inv_x = INV_W'(32768);
    s.inv_y = INV_W'(98304);
    apply_settings(s);
    send_pos(1, 1);
    send_pos(-1, -1);
    send_pos(3, -3);
    send_pos(-3, 3);
    quiesce();
  endtask

  // Random pixels under random settings, through each idle mix in turn.
  task automatic test_random_pixels();
    int per_chunk;
    int chunk;
    per_chunk = N_RANDOM / (4 * N_CHUNKS) + 1;
    chunk = 0;
    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int c = 0; c < N_CHUNKS; c++) begin
        apply_settings(pick_settings(chunk));
        chunk++;
        for (int i = 0; i < per_chunk; i++)
          send_pos(pick_pos(live.ctr_x), pick_pos(live.ctr_y));
        quiesce();
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  // Stall at random per the current mix; applies from the next edge on.
  always @(posedge clk)
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_texels.size() == 0) begin
        $error("unexpected result beat: tex_u=%0d tex_v=%0d", out_tex_u, out_tex_v);
        n_errors++;
      end else begin
        want_texel = pending_texels.pop_front();
        n_checked++;
        if (out_tex_u !== want_texel.u) begin
          $error("tex_u: expected %0d, got %0d", want_texel.u, out_tex_u);
          n_errors++;
        end
        if (out_tex_v !== want_texel.v) begin
          $error("tex_v: expected %0d, got %0d", want_texel.v, out_tex_v);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_clamp();
    test_mirror_edges();
    test_phase_offset();
    test_zero_recip();
    test_rounding_ties();
    test_random_pixels();

    // quiesce has already drained the pipe; flag anything still waiting
    quiesce();
    if (pending_texels.size() != 0) begin
      $error("%0d predicted beats never came out", pending_texels.size());
      n_errors++;
    end

    $display("tb: %0d pixel beats sent, %0d results checked, %0d register settings",
             n_sent, n_checked, n_settings);
    $display("tb: covered clamp, mirror edges, phase both ways, zero reciprocal, ties, "
             , "and four idle mixes");
    if (n_errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ttcw_pkg.sv
rtl/core/tiled_texture_coordinate_wrap_unit.sv
tb/tb.sv
